// ----- src/mrcq_pkg.sv -----
// Package for multi_range_clip_quantize: types, constants and shared codes.
`timescale 1ns / 1ps
package mrcq_pkg;

  localparam int MAX_RANGES_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CNT_W          = 5;
  localparam int VAL_W          = 64;
  localparam int FINE_W         = 63;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NONMONO = 2'd2;
  localparam logic [1:0] ST_BADLOAD = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_DIV,
    S_FIX,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the input item
    logic do_load;   // write table entry
    logic walk_init; // reset walk index and aggregates
    logic walk_step; // process one entry
    logic div_start; // launch the remainder unit
    logic div_step;  // one remainder bit
    logic fix;       // finish snap result
    logic out_load;  // move result to the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clip;
    logic walk_last; // current entry is the final one
    logic need_div;  // walk decided a snap is needed
    logic div_done;
    logic fail;      // empty or non monotonic
  } stat_t;

endpackage

// ----- src/mrcq_ctrl.sv -----
// Controller state machine for multi_range_clip_quantize.
`timescale 1ns / 1ps
module mrcq_ctrl
  import mrcq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  logic  out_busy,
  output logic  in_ready,
  output cmd_t  cmd,
  input  stat_t st
);

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_LOAD;
      S_LOAD: state_nxt = st.is_clip ? S_WALK : S_OUT;
      S_WALK: begin
        if (st.fail) state_nxt = S_OUT;
        else if (st.walk_last) state_nxt = st.need_div ? S_DIV : S_OUT;
      end
      S_DIV: if (st.div_done) state_nxt = S_FIX;
      S_FIX: state_nxt = S_OUT;
      S_OUT: if (!out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_fire;
      end
      S_LOAD: begin
        cmd.do_load = !st.is_clip;
        cmd.walk_init = 1'b1;
      end
      S_WALK: begin
        // step also on a failing entry so the status picks up the order check
        cmd.walk_step = 1'b1;
        cmd.div_start = st.walk_last && st.need_div && !st.fail;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_FIX: cmd.fix = 1'b1;
      S_OUT: cmd.out_load = !out_busy;
      default: ;
    endcase
  end

  a_walk_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> $past(state_r) == S_LOAD || $past(state_r) == S_WALK)
    else $error("walk entered from wrong state");
  a_fix_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIX |-> $past(state_r) == S_DIV)
    else $error("fix without division");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.walk_step && !cmd.div_step)
    else $error("ready while busy");

endmodule

// ----- src/mrcq_dp.sv -----
// Datapath for multi_range_clip_quantize: table, walk, remainder unit.
`timescale 1ns / 1ps
module mrcq_dp
  import mrcq_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             st,
  input  logic [CNT_W-1:0]  range_count,
  input  logic              in_cmd,
  input  logic [3:0]        in_index,
  input  logic [VAL_W-1:0]  in_start,
  input  logic [VAL_W-1:0]  in_stop,
  input  logic [VAL_W-1:0]  in_step,
  input  logic [VAL_W-1:0]  in_query,
  input  logic              in_snap,
  output logic [VAL_W-1:0]  res_value,
  output logic [1:0]        res_status,
  output logic [VAL_W-1:0]  res_lo,
  output logic [VAL_W-1:0]  res_hi,
  output logic [FINE_W-1:0] res_fine
);

  localparam logic [VAL_W-1:0] SIGN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W:0]   MAXR = MAX_RANGES;

  logic [3*VAL_W-1:0] mem [MAX_RANGES];

  // captured item
  logic              cmd_r;
  logic [3:0]        idx_r;
  logic [VAL_W-1:0]  a_r, b_r, c_r, v_r;
  logic              snap_r;
  logic [CNT_W:0]    n_r;

  // walk
  logic [IDX_W:0]    wi_r;
  logic [VAL_W-1:0]  lo_r, hi_r, pstop_r, res_r, snbase_r;
  logic [FINE_W-1:0] fine_r;
  logic              done_r, needdiv_r;
  logic [1:0]        stat_r;

  // remainder unit
  logic [VAL_W-1:0]  d_r, mag_r;
  logic [VAL_W:0]    rem_r;
  logic [6:0]        bit_r;

  logic [VAL_W-1:0]  e_start, e_stop, e_step;

  assign {e_step, e_stop, e_start} = mem[wi_r[IDX_W-1:0]];

  // table write
  always_ff @(posedge clk) begin
    if (cmd.do_load && !(($signed(b_r)) < $signed(a_r)) &&
        ({1'b0, idx_r} < MAXR[4:0] || MAX_RANGES > 15))
      mem[idx_r[IDX_W-1:0]] <= {c_r, b_r, a_r};
  end

  logic [VAL_W-1:0] gap, dv_lo, dv_hi, mag_n;
  logic last_i;
  assign gap   = (e_start ^ SIGN) - (pstop_r ^ SIGN);
  assign dv_lo = (e_start ^ SIGN) - (v_r ^ SIGN);
  assign dv_hi = (v_r ^ SIGN) - (pstop_r ^ SIGN);
  assign mag_n = e_step[VAL_W-1] ? (~e_step + 1'b1) : e_step;
  assign last_i = ({{(CNT_W-IDX_W){1'b0}}, wi_r} + 1'b1) >= n_r;

  logic [VAL_W:0] rsh;
  logic [VAL_W:0] rsub;
  assign rsh  = {rem_r[VAL_W-1:0], d_r[bit_r[5:0]]};
  assign rsub = rsh - {1'b0, mag_r};

  logic [VAL_W-1:0] rem64, q64, mhalf;
  logic [VAL_W:0]   qs, sum;
  assign rem64 = rem_r[VAL_W-1:0];
  assign q64   = d_r - rem64;
  assign mhalf = mag_r - rem64;
  assign qs    = (rem64 >= mhalf) ? ({1'b0, q64} + {1'b0, mag_r}) : {1'b0, q64};
  assign sum   = {1'b0, snbase_r ^ SIGN} + {1'b0, qs[VAL_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd; idx_r <= in_index;
      a_r <= in_start; b_r <= in_stop; c_r <= in_step;
      v_r <= in_query; snap_r <= in_snap;
      n_r <= ({1'b0, range_count} > MAXR[CNT_W:0]) ? MAXR[CNT_W:0] : {1'b0, range_count};
    end
    if (cmd.walk_init) begin
      wi_r <= '0; done_r <= 1'b0; needdiv_r <= 1'b0; fine_r <= '0;
      res_r <= '0; lo_r <= '0; hi_r <= '0;
      stat_r <= cmd_r ? ((n_r == '0) ? ST_EMPTY : ST_OK)
                      : (($signed(b_r) < $signed(a_r)) ? ST_BADLOAD : ST_OK);
    end
    if (cmd.walk_step) begin
      wi_r <= wi_r + 1'b1;
      pstop_r <= e_stop;
      if (wi_r != '0 && $signed(e_start) < $signed(pstop_r)) stat_r <= ST_NONMONO;
      if (wi_r == '0 || $signed(e_start) < $signed(lo_r)) lo_r <= e_start;
      if (wi_r == '0 || $signed(e_stop) > $signed(hi_r)) hi_r <= e_stop;
      begin
        logic [FINE_W-1:0] f, g;
        f = fine_r;
        if ($signed(e_step) > 0 && (f == '0 || e_step[FINE_W-1:0] < f))
          f = e_step[FINE_W-1:0];
        if (wi_r != '0 && $signed(e_start) > $signed(pstop_r)) begin
          g = gap[VAL_W-1] ? {FINE_W{1'b1}} : gap[FINE_W-1:0];
          if (f == '0 || g < f) f = g;
        end
        fine_r <= f;
      end
      if (!done_r) begin
        if ($signed(v_r) < $signed(e_start)) begin
          done_r <= 1'b1;
          res_r <= (wi_r == '0 || dv_lo < dv_hi) ? e_start : pstop_r;
        end else if ($signed(v_r) <= $signed(e_stop)) begin
          done_r <= 1'b1;
          res_r <= v_r;
          if (snap_r && e_step != '0) begin
            needdiv_r <= 1'b1;
            snbase_r <= e_start;
            mag_r <= mag_n;
            d_r <= (v_r ^ SIGN) - (e_start ^ SIGN);
          end
        end else if (last_i) begin
          res_r <= e_stop;
        end
      end
    end
    if (cmd.div_start) begin
      rem_r <= '0; bit_r <= 7'd63;
    end
    if (cmd.div_step) begin
      rem_r <= rsub[VAL_W] ? rsh : rsub;
      bit_r <= bit_r - 1'b1;
    end
    if (cmd.fix)
      res_r <= (qs[VAL_W] || sum[VAL_W]) ? {1'b0, {(VAL_W-1){1'b1}}}
                                         : (sum[VAL_W-1:0] ^ SIGN);
  end

  assign st.is_clip   = cmd_r;
  assign st.walk_last = last_i;
  assign st.need_div  = needdiv_r || (!done_r && snap_r && e_step != '0 &&
                        !($signed(v_r) < $signed(e_start)) &&
                        $signed(v_r) <= $signed(e_stop));
  assign st.div_done  = bit_r == '0;
  assign st.fail      = cmd_r && (stat_r != ST_OK ||
                        (wi_r != '0 && $signed(e_start) < $signed(pstop_r)));

  logic ok;
  assign ok = cmd_r && stat_r == ST_OK;
  assign res_status = stat_r;
  assign res_value  = ok ? res_r : '0;
  assign res_lo     = ok ? lo_r : '0;
  assign res_hi     = ok ? hi_r : '0;
  assign res_fine   = ok ? fine_r : '0;

  a_div_mag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> mag_r != '0) else $error("zero divisor");
  a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |-> rem_r[VAL_W-1:0] < mag_r) else $error("remainder too big");
  a_fail_stat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_init |=> cmd_r || stat_r == ST_OK || stat_r == ST_BADLOAD)
    else $error("bad load status");

endmodule

// ----- src/multi_range_clip_quantize.sv -----
// Top level of multi_range_clip_quantize.
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser cmd, tdata fields
//  out_    | out | out_tvalid/tready  | tdata result fields
//  cfg_    | in  | cfg_wr_en          | range_count
// A load passes through the load and output states; a clip walks the table,
// one entry per cycle, then when snapping runs a 64-bit bit-serial remainder unit.
// Reset (synchronous, active low) clears control and range_count; table is undefined.
// A new item may enter while a result waits in the output register; its own result
// then holds the controller until that register is free.
`timescale 1ns / 1ps
module multi_range_clip_quantize
  import mrcq_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,       // cmd
  input  logic [263:0] in_tdata,       // entry_index, range_start, range_stop,
                                       // range_step, query_value, snap_to_step, pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [263:0] out_tdata,      // clipped_value, status, lowest_start,
                                       // highest_stop, finest_step, pad
  input  logic         cfg_wr_en,
  input  logic [4:0]   cfg_wr_data     // range_count
);

  logic [CNT_W-1:0] count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cfg_wr_en) count_r <= cfg_wr_data;
  end

  cmd_t  cmd;
  stat_t st;
  logic  in_fire;
  assign in_fire = in_tvalid && in_tready;

  logic [VAL_W-1:0]  rv, rl, rh;
  logic [1:0]        rs;
  logic [FINE_W-1:0] rf;

  mrcq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(out_tvalid),
    .in_ready(in_tready), .cmd(cmd), .st(st)
  );

  mrcq_dp #(.MAX_RANGES(MAX_RANGES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st), .range_count(count_r),
    .in_cmd(in_tuser), .in_index(in_tdata[3:0]),
    .in_start(in_tdata[67:4]), .in_stop(in_tdata[131:68]),
    .in_step(in_tdata[195:132]), .in_query(in_tdata[259:196]),
    .in_snap(in_tdata[260]),
    .res_value(rv), .res_status(rs), .res_lo(rl), .res_hi(rh), .res_fine(rf)
  );

  // output register
  logic [263:0] odata_r;
  logic         ovalid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.out_load) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
    if (cmd.out_load) odata_r <= {7'b0, rf, rh, rl, rs, rv};
  end
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !ovalid_r) else $error("result overwritten");

endmodule

// ----- tb/tb.sv -----
// Testbench for multi_range_clip_quantize: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module tb;
  import mrcq_pkg::*;

  localparam logic [63:0] SGN     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;
  localparam logic        CMD_LOAD = 1'b0;
  localparam logic        CMD_CLIP = 1'b1;
  localparam int          TABLE_DEPTH = MAX_RANGES_DEF;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  status;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [62:0] fine;
  } clip_result_t;

  // Predictor plus queue of expected results
  class clip_scoreboard;
    logic signed [63:0] starts[TABLE_DEPTH];
    logic signed [63:0] stops[TABLE_DEPTH];
    logic signed [63:0] steps[TABLE_DEPTH];
    int unsigned        range_count;
    clip_result_t       pending[$];
    int                 errors;

    function new();
      range_count = 0;
      errors = 0;
      foreach (starts[i]) begin
        starts[i] = '0; stops[i] = '0; steps[i] = '0;
      end
    endfunction

    function void set_count(logic [4:0] c);
      range_count = c;
    endfunction

    function int unsigned used_entries();
      return (range_count > TABLE_DEPTH) ? TABLE_DEPTH : range_count;
    endfunction

    // append one expected result
    function void expect_result(clip_result_t r);
      pending.insert(pending.size(), r);
    endfunction

    // a - b for a >= b, exact as unsigned
    static function logic [63:0] span(logic [63:0] a, logic [63:0] b);
      return (a ^ SGN) - (b ^ SGN);
    endfunction

    // round v to start + k*|step|, half up, saturating high
    static function logic [63:0] snap_grid(logic [63:0] start, logic [63:0] step,
                                           logic [63:0] v);
      logic [63:0] mag, d, rem, q;
      logic [64:0] t, s;
      logic        carry;
      mag = step[63] ? (64'd0 - step) : step;
      d = span(v, start);
      rem = d % mag;
      q = d - rem;
      carry = 1'b0;
      if (rem >= mag - rem) begin
        t = {1'b0, q} + {1'b0, mag};
        carry = t[64];
        q = t[63:0];
      end
      s = {1'b0, start ^ SGN} + {1'b0, q};
      if (carry || s[64]) return MAX_S64;
      return s[63:0] ^ SGN;
    endfunction

    function void note_input(logic cmd, logic [263:0] d);
      clip_result_t r;
      logic signed [63:0] rs, re, rp, v, lo, hi, prev_stop;
      logic [63:0] res, fine, c;
      logic        snap, done;
      int unsigned n;
      rs = d[67:4]; re = d[131:68]; rp = d[195:132]; v = d[259:196]; snap = d[260];
      r = '{default: '0};
      if (cmd == CMD_LOAD) begin
        if (re < rs) r.status = ST_BADLOAD;
        else begin
          starts[d[3:0]] = rs; stops[d[3:0]] = re; steps[d[3:0]] = rp;
        end
        expect_result(r);
        return;
      end
      n = used_entries();
      if (n == 0) begin
        r.status = ST_EMPTY;
        expect_result(r);
        return;
      end
      for (int i = 1; i < n; i++)
        if (starts[i] < stops[i-1]) begin
          r.status = ST_NONMONO;
          expect_result(r);
          return;
        end
      // walk the ranges
      prev_stop = stops[0];
      res = '0;
      done = 1'b0;
      for (int i = 0; i < n && !done; i++) begin
        if (v < starts[i]) begin
          if (i == 0) res = starts[0];
          else res = (span(starts[i], v) < span(v, prev_stop)) ? starts[i] : prev_stop;
          done = 1'b1;
        end else if (v <= stops[i]) begin
          res = (!snap || steps[i] == 0) ? v : snap_grid(starts[i], steps[i], v);
          done = 1'b1;
        end else prev_stop = stops[i];
      end
      if (!done) res = prev_stop;
      // lowest start, highest stop, finest step or gap
      lo = starts[0]; hi = stops[0]; fine = '0;
      for (int i = 0; i < n; i++) begin
        if (starts[i] < lo) lo = starts[i];
        if (stops[i] > hi) hi = stops[i];
        if (steps[i] > 0) begin
          c = steps[i];
          if (fine == 0 || c < fine) fine = c;
        end
        if (i > 0 && starts[i] > stops[i-1]) begin
          c = span(starts[i], stops[i-1]);
          if (c > MAX_S64) c = MAX_S64;
          if (fine == 0 || c < fine) fine = c;
        end
      end
      r.value = res; r.status = ST_OK; r.lo = lo; r.hi = hi; r.fine = fine[62:0];
      expect_result(r);
    endfunction

    // compare one result against the oldest expected item
    function void check_result(logic [263:0] d);
      clip_result_t e;
      if (pending.size() == 0) begin
        $error("result with no item outstanding: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[63:0] !== e.value) begin
        $error("clipped_value: expected %0d, got %0d", $signed(e.value), $signed(d[63:0]));
        errors++;
      end
      if (d[65:64] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, d[65:64]);
        errors++;
      end
      if (d[129:66] !== e.lo) begin
        $error("lowest_start: expected %0d, got %0d", $signed(e.lo), $signed(d[129:66]));
        errors++;
      end
      if (d[193:130] !== e.hi) begin
        $error("highest_stop: expected %0d, got %0d", $signed(e.hi), $signed(d[193:130]));
        errors++;
      end
      if (d[256:194] !== e.fine) begin
        $error("finest_step: expected %0d, got %0d", e.fine, d[256:194]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid, in_tready, in_tuser;
  logic [263:0] in_tdata;
  logic         out_tvalid, out_tready;
  logic [263:0] out_tdata;
  logic         cfg_wr_en;
  logic [4:0]   cfg_wr_data;

  clip_scoreboard sb = new();
  int in_idle_pct, out_stall_pct, hold_left;

  multi_range_clip_quantize DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // watch both channels and the register port
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.set_count(cfg_wr_data);
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("multi_range_clip_quantize verification failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random magnitude, mostly small, below 2^57
  function automatic logic [63:0] rand_mag();
    int k;
    k = $urandom_range(56);
    return (64'd1 << k) | (rand64() >> (64 - k));
  endfunction

  task automatic send(logic cmd, logic [263:0] d);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // unused fields carry random noise
  task automatic load(logic [3:0] idx, logic [63:0] rs, logic [63:0] re, logic [63:0] rp);
    logic [263:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom};
    d[3:0] = idx; d[67:4] = rs; d[131:68] = re; d[195:132] = rp;
    send(CMD_LOAD, d);
  endtask

  task automatic clip(logic [63:0] v, logic snap);
    logic [263:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom};
    d[259:196] = v; d[260] = snap;
    send(CMD_CLIP, d);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_range_count(logic [4:0] c);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= c;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // fill all entries with ascending ranges
  task automatic load_ordered_table();
    logic [63:0] cursor, rs, re, rp;
    cursor = -(64'd1 << 62) + (rand64() >> 3);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rs = ($urandom_range(3) == 0) ? cursor : cursor + rand_mag();
      re = ($urandom_range(7) == 0) ? rs : rs + rand_mag();
      case ($urandom_range(4))
        0: rp = '0;
        1: rp = 64'($urandom_range(1, 9)) << 16;
        2: rp = -rand_mag();
        3: rp = rand_mag();
        default: rp = rand64();
      endcase
      load(i[3:0], rs, re, rp);
      cursor = re;
    end
  endtask

  // query value aimed at an entry, its edges or a gap
  function automatic logic [63:0] pick_query();
    int unsigned n, j;
    logic [63:0] s, e, w;
    n = sb.used_entries();
    if (n == 0) return rand64();
    j = $urandom_range(n - 1);
    s = sb.starts[j]; e = sb.stops[j];
    w = clip_scoreboard::span(e, s);
    case ($urandom_range(7))
      0, 1: return s + ((w == '1) ? rand64() : rand64() % (w + 1));
      2: return (s == MIN_S64) ? s : s - 1;
      3: return (e == MAX_S64) ? e : e + 1;
      4: return s;
      5: return e;
      6: return (j == 0) ? s - 64'd3 : sb.stops[j-1] + (clip_scoreboard::span(s,
                 sb.stops[j-1]) >> 1);
      default: return rand64();
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tuser = 1'b0; in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0;
    in_idle_pct = 0; out_stall_pct = 0; hold_left = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, rejected load
    clip(64'd5, 1'b1);
    load(4'd0, 64'd10, 64'd9, 64'd1);
    for (int i = 0; i < TABLE_DEPTH; i++)
      load(i[3:0], 64'(100 + i * 10), 64'(105 + i * 10), '0);
    load(4'd0, 64'd0, 64'd10, 64'd4);
    load(4'd1, 64'd20, 64'd30, -64'd3);
    load(4'd2, 64'd40, 64'd40, '0);
    set_range_count(5'd3);
    clip(64'd2, 1'b1);    // half rounds up
    clip(64'd15, 1'b0);   // tie in gap goes to lower stop
    clip(64'd16, 1'b0);
    clip(-64'd5, 1'b1);   // below everything
    clip(64'd50, 1'b1);   // above everything
    clip(64'd25, 1'b1);   // negative step
    clip(64'd9, 1'b0);
    set_range_count(5'd31); // count above table depth
    clip(MAX_S64, 1'b1);
    // huge gap saturates finest_step
    load(4'd0, MIN_S64, MIN_S64, '0);
    load(4'd1, MAX_S64, MAX_S64, MIN_S64);
    set_range_count(5'd2);
    clip(64'd0, 1'b0);
    // most negative step, rounding past stop saturates
    load(4'd0, MIN_S64, MAX_S64, MIN_S64);
    set_range_count(5'd1);
    clip(MAX_S64, 1'b1);
    clip(64'd0, 1'b1);
    clip(MIN_S64, 1'b1);
    // not monotonic
    load(4'd1, -64'd1, 64'd0, '0);
    set_range_count(5'd2);
    clip(64'd0, 1'b0);

    // random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct   = (ph == 1) ? 87 : (ph == 3) ? 12 : 0;
      out_stall_pct = (ph == 2) ? 87 : (ph == 3) ? 12 : 0;
      for (int g = 0; g < 7; g++) begin
        case ($urandom_range(7))
          0: set_range_count(5'd0);
          1: set_range_count(5'($urandom_range(17, 31)));
          2: set_range_count(5'($urandom_range(1, 15)));
          default: set_range_count(5'd16);
        endcase
        if (ph == 0 && g == 1) hold_left = 400;
        load_ordered_table();
        // broken sequences: stray loads that may reject or overlap
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(1, 3))
            load(4'($urandom), rand64(), rand64(), rand64());
        repeat (10) clip(pick_query(), 1'($urandom));
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("multi_range_clip_quantize verification clean");
    else
      $display("multi_range_clip_quantize verification failed");
    $finish;
  end

endmodule

// ----- multi_range_clip_quantize.f -----
src/mrcq_pkg.sv
src/mrcq_ctrl.sv
src/mrcq_dp.sv
src/multi_range_clip_quantize.sv
tb/tb.sv
